/* rtl/core/mrpt_pkg.sv */
// shared constants, types and helpers of the miller-rabin prime test
`timescale 1ns / 1ps
`default_nettype none

package mrpt_pkg;

  localparam int NUM_WIDTH = 63;
  localparam int MAX_BASES = 11;
  localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);
  localparam int IDX_WIDTH = 4;
  localparam logic [IDX_WIDTH-1:0] RESET_BASE_COUNT = IDX_WIDTH'(10);

  typedef logic [NUM_WIDTH-1:0] num_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SPLIT,
    ST_BASE,
    ST_REDUCE,
    ST_EXP,
    ST_MUL_A,
    ST_MUL_B,
    ST_SQ,
    ST_SQ_MUL,
    ST_FIN_P,
    ST_FIN_C
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SPLIT,
    CMD_BASE_INIT,
    CMD_REDUCE,
    CMD_MUL_AB,
    CMD_MUL_BB,
    CMD_ACC_MUL_BB,
    CMD_WR_B,
    CMD_SQ_INIT,
    CMD_MUL_WW,
    CMD_WR_W,
    CMD_NEXT_BASE,
    CMD_RES_PRIME,
    CMD_RES_COMP
  } cmd_t;

  typedef struct packed {
    logic below_three;
    logic is_two;
    logic d_odd;
    logic idx_done;
    logic base_eq_n;
    logic b_ge_n;
    logic e_zero;
    logic e_lsb;
    logic mul_idle;
    logic k_done;
    logic root_bad;
    logic w_is_one;
    logic out_free;
  } status_t;

  function automatic num_t base_value(input logic [IDX_WIDTH-1:0] idx);
    logic [5:0] v;
    case (idx)
      4'd0:    v = 6'd2;
      4'd1:    v = 6'd3;
      4'd2:    v = 6'd5;
      4'd3:    v = 6'd7;
      4'd4:    v = 6'd11;
      4'd5:    v = 6'd13;
      4'd6:    v = 6'd17;
      4'd7:    v = 6'd19;
      4'd8:    v = 6'd23;
      4'd9:    v = 6'd29;
      4'd10:   v = 6'd31;
      default: v = 6'd0;
    endcase
    return NUM_WIDTH'(v);
  endfunction

  // (x + y) mod m for x, y < m
  function automatic num_t add_mod(input num_t x, input num_t y, input num_t m);
    logic [NUM_WIDTH:0] sm;
    sm = {1'b0, x} + {1'b0, y};
    if (sm >= {1'b0, m}) begin
      sm = sm - {1'b0, m};
    end
    return sm[NUM_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mrpt_datapath.sv */
// datapath: operand registers, bit-serial modular multiplier, result word
`timescale 1ns / 1ps
`default_nettype none

module mrpt_datapath
  import mrpt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  input  wire logic                 cfg_wr_en,
  input  wire logic [IDX_WIDTH-1:0] cfg_wr_data,
  input  wire logic [NUM_WIDTH-1:0] candidate,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      is_prime
);

  logic [IDX_WIDTH-1:0] base_count;
  logic [IDX_WIDTH-1:0] limit;
  logic [IDX_WIDTH-1:0] idx;
  num_t n, nm1, d, e, acc, b, mx, my, macc;
  logic [CNT_WIDTH-1:0] s, k;

  assign limit = (base_count > IDX_WIDTH'(MAX_BASES)) ? IDX_WIDTH'(MAX_BASES) : base_count;

  always_comb begin
    status.below_three = (n < NUM_WIDTH'(3));
    status.is_two      = (n == NUM_WIDTH'(2));
    status.d_odd       = d[0];
    status.idx_done    = (idx >= limit);
    status.base_eq_n   = (n == base_value(idx));
    status.b_ge_n      = (b >= n);
    status.e_zero      = (e == '0);
    status.e_lsb       = e[0];
    status.mul_idle    = (my == '0);
    status.k_done      = (k == s);
    status.root_bad    = (macc == NUM_WIDTH'(1)) && (acc != NUM_WIDTH'(1)) && (acc != nm1);
    status.w_is_one    = (acc == NUM_WIDTH'(1));
    status.out_free    = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_count <= RESET_BASE_COUNT;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_count <= cfg_wr_data;
      end
      if (cmd == CMD_RES_PRIME || cmd == CMD_RES_COMP) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    // shift-and-add multiplier step runs whenever multiplier bits remain
    if (my != '0) begin
      if (my[0]) begin
        macc <= add_mod(macc, mx, n);
      end
      mx <= add_mod(mx, mx, n);
      my <= my >> 1;
    end
    case (cmd)
      CMD_LOAD: begin
        n   <= candidate;
        nm1 <= candidate - NUM_WIDTH'(1);
        d   <= candidate - NUM_WIDTH'(1);
        s   <= '0;
        idx <= '0;
        my  <= '0;
      end
      CMD_SPLIT: begin
        d <= d >> 1;
        s <= s + CNT_WIDTH'(1);
      end
      CMD_BASE_INIT: begin
        b   <= base_value(idx);
        acc <= NUM_WIDTH'(1);
        e   <= d;
      end
      CMD_REDUCE: begin
        b <= b - n;
      end
      CMD_MUL_AB: begin
        mx   <= acc;
        my   <= b;
        macc <= '0;
      end
      CMD_MUL_BB: begin
        mx   <= b;
        my   <= b;
        macc <= '0;
      end
      CMD_ACC_MUL_BB: begin
        acc  <= macc;
        mx   <= b;
        my   <= b;
        macc <= '0;
      end
      CMD_WR_B: begin
        b <= macc;
        e <= e >> 1;
      end
      CMD_SQ_INIT: begin
        k <= '0;
      end
      CMD_MUL_WW: begin
        mx   <= acc;
        my   <= acc;
        macc <= '0;
      end
      CMD_WR_W: begin
        acc <= macc;
        k   <= k + CNT_WIDTH'(1);
      end
      CMD_NEXT_BASE: begin
        idx <= idx + IDX_WIDTH'(1);
      end
      CMD_RES_PRIME: begin
        is_prime <= 1'b1;
      end
      CMD_RES_COMP: begin
        is_prime <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/mrpt_ctrl.sv */
// controller: sequences split, exponentiation, squaring and result per candidate
`timescale 1ns / 1ps
`default_nettype none

module mrpt_ctrl
  import mrpt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.below_three) begin
          state_next = status.is_two ? ST_FIN_P : ST_FIN_C;
        end else begin
          state_next = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (status.d_odd) begin
          state_next = ST_BASE;
        end else begin
          cmd = CMD_SPLIT;
        end
      end
      ST_BASE: begin
        if (status.idx_done || status.base_eq_n) begin
          state_next = ST_FIN_P;
        end else begin
          cmd        = CMD_BASE_INIT;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status.b_ge_n) begin
          cmd = CMD_REDUCE;
        end else begin
          state_next = ST_EXP;
        end
      end
      ST_EXP: begin
        if (status.e_zero) begin
          cmd        = CMD_SQ_INIT;
          state_next = ST_SQ;
        end else if (status.e_lsb) begin
          cmd        = CMD_MUL_AB;
          state_next = ST_MUL_A;
        end else begin
          cmd        = CMD_MUL_BB;
          state_next = ST_MUL_B;
        end
      end
      ST_MUL_A: begin
        if (status.mul_idle) begin
          cmd        = CMD_ACC_MUL_BB;
          state_next = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        if (status.mul_idle) begin
          cmd        = CMD_WR_B;
          state_next = ST_EXP;
        end
      end
      ST_SQ: begin
        if (status.k_done) begin
          if (status.w_is_one) begin
            cmd        = CMD_NEXT_BASE;
            state_next = ST_BASE;
          end else begin
            state_next = ST_FIN_C;
          end
        end else begin
          cmd        = CMD_MUL_WW;
          state_next = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: begin
        if (status.mul_idle) begin
          if (status.root_bad) begin
            state_next = ST_FIN_C;
          end else begin
            cmd        = CMD_WR_W;
            state_next = ST_SQ;
          end
        end
      end
      ST_FIN_P: begin
        if (status.out_free) begin
          cmd        = CMD_RES_PRIME;
          state_next = ST_IDLE;
        end
      end
      ST_FIN_C: begin
        if (status.out_free) begin
          cmd        = CMD_RES_COMP;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/miller_rabin_prime_test.sv */
// top level of the miller-rabin prime test
//
// input channel: candidate with in_valid / in_stall; one word is taken
// while the controller is idle. output channel: is_prime with
// out_valid / out_stall, held in an output register, so the next
// candidate is taken while a finished result still waits.
// base_count is written through cfg_wr_en / cfg_wr_data (low 4 bits,
// values above 11 act as 11); it resets to 10.
// candidates below 3 are decided without testing a base; otherwise per base
// the test runs up to two modular multiplications per bit of d, each
// stepping one multiplier bit per cycle (up to 63) in the shared
// shift-and-add unit, plus s squarings.
// one candidate is in work at a time.
// reset (synchronous, rst high) returns the controller to idle and
// empties the output register. a stalled result holds and the
// controller waits for it before writing the next one.
`timescale 1ns / 1ps
`default_nettype none

module miller_rabin_prime_test
  import mrpt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [IDX_WIDTH-1:0] cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [NUM_WIDTH-1:0] candidate,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      is_prime
);

  cmd_t    cmd;
  status_t status;

  mrpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mrpt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .candidate   (candidate),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_prime    (is_prime)
  );

endmodule

`default_nettype wire

/* verif/miller_rabin_prime_test_tb.sv */
// testbench for the miller-rabin prime test: queued stimulus, predicted verdicts, checks
`timescale 1ns / 1ps

module miller_rabin_prime_test_tb;
  import mrpt_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 64_000_000;
  localparam int unsigned PRIME_BASES[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [IDX_WIDTH-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  num_t candidate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic is_prime;

  miller_rabin_prime_test i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .candidate(candidate),
    .out_valid(out_valid), .out_stall(out_stall), .is_prime(is_prime)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  num_t pending_words[$];
  bit verdicts_due[$];
  int unsigned bases_tried = 10;
  int unsigned errors = 0;
  int unsigned verdicts_seen = 0;
  int unsigned send_gap = 0;
  int unsigned recv_hold = 0;
  bit quiet_send = 1'b0;
  bit quiet_recv = 1'b0;
  longint unsigned cycles = 0;

  function automatic num_t mod_mult(num_t a, num_t b, num_t m);
    logic [127:0] p;
    p = {65'b0, a} * {65'b0, b};
    return num_t'(p % {65'b0, m});
  endfunction

  function automatic num_t mod_power(num_t b, num_t e, num_t m);
    num_t acc;
    acc = (m == 1) ? num_t'(0) : num_t'(1);
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mod_mult(acc, b, m);
      b = mod_mult(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit predict_prime(num_t n, int unsigned nbases);
    num_t d, w, sq;
    int unsigned s, lim;
    s = 0;
    if (n <= 2) return n == 2;
    d = n - 1;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    lim = (nbases > 11) ? 11 : nbases;
    for (int i = 0; i < lim; i++) begin
      if (num_t'(PRIME_BASES[i]) == n) return 1'b1;
      w = mod_power(num_t'(PRIME_BASES[i]), d, n);
      for (int k = 0; k < s; k++) begin
        sq = mod_mult(w, w, n);
        if (sq == 1 && w != 1 && w != n - 1) return 1'b0;
        w = sq;
      end
      if (w != 1) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic num_t random_candidate();
    int unsigned w;
    num_t v;
    w = ($urandom_range(0, 11) == 0) ? 63 : $urandom_range(2, 20);
    v = num_t'({$urandom, $urandom});
    if (w < 63) v = v & ((num_t'(1) << w) - 1);
    if ($urandom_range(0, 3) != 0) v[0] = 1'b1;
    return v;
  endfunction

  // sender: offers the queued words with random gaps
  always @(posedge clk) begin
    bit fire;
    fire = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        verdicts_due.push_back(predict_prime(candidate, bases_tried));
        void'(pending_words.pop_front());
        if ($urandom_range(0, 19) == 0) quiet_send = !quiet_send;
        send_gap = quiet_send ? 0 : $urandom_range(0, 16);
      end
      if (!in_valid || fire) begin
        if (send_gap == 0 && pending_words.size() > 0) begin
          in_valid <= 1'b1;
          candidate <= pending_words[0];
        end else begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // receiver: checks each verdict, stalls at random, once for a long stretch
  always @(posedge clk) begin
    bit want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected word, actual is_prime=%0b", $time, is_prime);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (want !== is_prime) begin
            $display("%0t: is_prime mismatch, expected %0b actual %0b", $time, want, is_prime);
            errors++;
          end
        end
        if ($urandom_range(0, 19) == 0) quiet_recv = !quiet_recv;
        recv_hold = quiet_recv ? 0 : $urandom_range(0, 16);
        if (verdicts_seen == 30) recv_hold = 3000;
      end
      out_stall <= (recv_hold > 0);
      if (recv_hold > 0) recv_hold--;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || verdicts_due.size() > 0 || in_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_bases(int unsigned v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= IDX_WIDTH'(v);
    bases_tried = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int unsigned settings[5] = '{1, 11, 15, 0, 7};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // edge values, carmichael and strong pseudoprimes, large primes, largest value
    pending_words = '{0, 1, 2, 3, 4, 5, 9, 25, 31, 37, 49, 561, 2047, 63'd3215031751,
                      63'd3825123056546413051, 63'd2305843009213693951,
                      63'h7fff_ffff_ffff_ffff, 63'h7fff_ffff_ffff_ffe7};
    wait_drained();
    foreach (settings[p]) begin
      set_bases(settings[p]);
      for (int i = 0; i < 6; i++)
        pending_words.push_back(num_t'(PRIME_BASES[$urandom_range(0, 10)]));
      pending_words.push_back(num_t'(2047));
      pending_words.push_back(63'd3825123056546413051);
      for (int i = 0; i < 12; i++) pending_words.push_back(random_candidate());
      wait_drained();
    end
    set_bases($urandom_range(1, 11));
    for (int i = 0; i < 22; i++) pending_words.push_back(random_candidate());
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* miller_rabin_prime_test.f */
rtl/core/mrpt_pkg.sv
rtl/core/mrpt_datapath.sv
rtl/core/mrpt_ctrl.sv
rtl/core/miller_rabin_prime_test.sv
verif/miller_rabin_prime_test_tb.sv
